// ===== rtl/cafb_pkg.sv =====
package cafb_pkg;

	localparam int STD_EXACT_SLOTS = 16;
	localparam int EXT_EXACT_SLOTS = 8;
	localparam int STD_RANGE_SLOTS = 8;
	localparam int EXT_RANGE_SLOTS = 4;

	localparam int MAX_RES = 32;

	localparam int ENTRY_W = 59;
	localparam int KEY_W = 30;

	localparam int RAM_DEPTH = STD_EXACT_SLOTS + STD_RANGE_SLOTS + EXT_EXACT_SLOTS +
		EXT_RANGE_SLOTS;
	localparam int ADDR_W = $clog2(RAM_DEPTH);

	localparam int MAX_SLOTS_A = (STD_EXACT_SLOTS > EXT_EXACT_SLOTS) ?
		STD_EXACT_SLOTS : EXT_EXACT_SLOTS;
	localparam int MAX_SLOTS_B = (STD_RANGE_SLOTS > EXT_RANGE_SLOTS) ?
		STD_RANGE_SLOTS : EXT_RANGE_SLOTS;
	localparam int MAX_SLOTS = (MAX_SLOTS_A > MAX_SLOTS_B) ? MAX_SLOTS_A : MAX_SLOTS_B;
	localparam int CNT_W = $clog2(MAX_SLOTS + 1);

	localparam int MAX_WORDS = (STD_EXACT_SLOTS + 1) / 2 + STD_RANGE_SLOTS +
		EXT_EXACT_SLOTS + 2 * EXT_RANGE_SLOTS;
	localparam int IDX_W = $clog2(MAX_WORDS + 1);
	localparam int RES_W = $clog2(MAX_RES + 1);

	localparam logic [15:0] FILL16 = 16'hFFFF;

	localparam logic [1:0] CMD_EXACT = 2'd0;
	localparam logic [1:0] CMD_RANGE = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;

	// lists in table order
	typedef enum logic [1:0] {
		LST_SE = 2'd0,
		LST_SR = 2'd1,
		LST_EE = 2'd2,
		LST_ER = 2'd3
	} lst_t;

	typedef struct packed {
		lst_t        sec;
		logic        half;
		logic [15:0] hi16;
	} pack_ctl_t;

	function automatic logic [ADDR_W-1:0] list_base(lst_t l);
		logic [ADDR_W-1:0] b;
		case (l)
			LST_SE:  b = '0;
			LST_SR:  b = ADDR_W'(STD_EXACT_SLOTS);
			LST_EE:  b = ADDR_W'(STD_EXACT_SLOTS + STD_RANGE_SLOTS);
			default: b = ADDR_W'(STD_EXACT_SLOTS + STD_RANGE_SLOTS + EXT_EXACT_SLOTS);
		endcase
		return b;
	endfunction

	function automatic logic [CNT_W-1:0] list_slots(lst_t l);
		logic [CNT_W-1:0] s;
		case (l)
			LST_SE:  s = CNT_W'(STD_EXACT_SLOTS);
			LST_SR:  s = CNT_W'(STD_RANGE_SLOTS);
			LST_EE:  s = CNT_W'(EXT_EXACT_SLOTS);
			default: s = CNT_W'(EXT_RANGE_SLOTS);
		endcase
		return s;
	endfunction

	function automatic logic [KEY_W-1:0] key_of(lst_t l, logic [ENTRY_W-1:0] e);
		logic [KEY_W-1:0] k;
		case (l)
			LST_SE:  k = KEY_W'(e[11:0]);
			LST_SR:  k = KEY_W'(e[22:11]);
			LST_EE:  k = e[29:0];
			default: k = e[58:29];
		endcase
		return k;
	endfunction

	function automatic logic [15:0] entry16(logic ch, logic [10:0] id);
		return {2'b00, ch, id, 2'b00};
	endfunction

endpackage

// ===== rtl/cafb_req_if.sv =====
interface cafb_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic        extended;
	logic        channel;
	logic [28:0] id_low;
	logic [28:0] id_high;

	modport source(output valid, command, extended, channel, id_low, id_high, input ready);
	modport sink(input valid, command, extended, channel, id_low, id_high, output ready);
endinterface

// ===== rtl/cafb_rsp_if.sv =====
interface cafb_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        has_word;
	logic [4:0]  word_address;
	logic [31:0] table_word;
	logic        last;
	logic [7:0]  std_range_start;
	logic [7:0]  ext_exact_start;
	logic [7:0]  ext_range_start;
	logic [7:0]  table_end;
	logic        accept_all;

	modport source(output valid, status, has_word, word_address, table_word, last,
		std_range_start, ext_exact_start, ext_range_start, table_end, accept_all,
		input ready);
	modport sink(input valid, status, has_word, word_address, table_word, last,
		std_range_start, ext_exact_start, ext_range_start, table_end, accept_all,
		output ready);
endinterface

// ===== rtl/can_acceptance_filter_table_build.sv =====
// Channel | Dir | Payload
// req     | in  | command, extended, channel, id_low, id_high
// rsp     | out | status, has_word, word_address, table_word, last, offsets, accept_all
//
// One command at a time; req is ready only in idle. An add places its entry walking
// back from the list end; each entry shifted costs a RAM read, then a compare/write.
// Emit walks the sections in table order (read, data, out), packing standard exact
// pairs and splitting extended ranges into two words, with an empty read between
// sections. Clear and rejects give one response via S_RESP; command 3: accept only.
// Reset clears counts and filter-on; list RAM needs none. rsp stalls hold the
// sequencer only when the next word is ready to load.
module can_acceptance_filter_table_build (
	input logic       clk,
	input logic       arst_n,
	cafb_req_if.sink  req,
	cafb_rsp_if.source rsp
);
	import cafb_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_INS_RD   = 7'b0000010,
		S_INS_CHK  = 7'b0000100,
		S_EMIT_RD  = 7'b0001000,
		S_EMIT_DAT = 7'b0010000,
		S_EMIT_OUT = 7'b0100000,
		S_RESP     = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_q [4];
	logic             filt_q;
	lst_t             lst_q;
	logic [ENTRY_W-1:0] entry_q;
	logic [CNT_W-1:0] p_q;
	logic [1:0]       status_q;
	lst_t             sec_q;
	logic [CNT_W-1:0] i_q;
	logic             half_q;
	logic [15:0]      hi16_q;
	logic [ENTRY_W-1:0] hold_q;
	logic [31:0]      word_q;
	logic [RES_W-1:0] emit_n_q;

	// output register
	logic        ov_q;
	logic [1:0]  o_status_q;
	logic        o_has_q;
	logic [4:0]  o_addr_q;
	logic [31:0] o_word_q;
	logic        o_last_q;
	logic [7:0]  o_off_q [4];
	logic        o_acc_q;

	// list RAM
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

	cafb_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// word formatter; second extended range word comes from the held entry
	pack_ctl_t          pctl;
	logic [ENTRY_W-1:0] pdata;
	logic [31:0]        pword;

	assign pctl  = '{sec: sec_q, half: half_q, hi16: hi16_q};
	assign pdata = (sec_q == LST_ER && half_q) ? hold_q : ram_rdata;

	cafb_pack u_pack (
		.ctl (pctl),
		.data(pdata),
		.word(pword)
	);

	// section offsets in bytes (word counts times four), from the current counts
	logic [IDX_W-1:0] w0, w1, w2, w3;
	logic [RES_W-1:0] total;
	logic [7:0]       offs [4];

	always_comb begin
		w0 = (IDX_W'(cnt_q[LST_SE]) + IDX_W'(1)) >> 1;
		w1 = w0 + IDX_W'(cnt_q[LST_SR]);
		w2 = w1 + IDX_W'(cnt_q[LST_EE]);
		w3 = w2 + IDX_W'({cnt_q[LST_ER], 1'b0});
		total = (w3 > IDX_W'(MAX_RES)) ? RES_W'(MAX_RES) : RES_W'(w3);
		offs[0] = 8'({w0, 2'b00});
		offs[1] = 8'({w1, 2'b00});
		offs[2] = 8'({w2, 2'b00});
		offs[3] = 8'({w3, 2'b00});
	end

	logic out_free;
	logic req_xfer;
	logic key_gt;
	logic last_word;
	lst_t req_lst;
	logic [1:0] req_status;

	assign out_free  = !ov_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign key_gt    = key_of(lst_q, ram_rdata) > key_of(lst_q, entry_q);
	assign last_word = (emit_n_q + RES_W'(1)) == total;

	// target list and reject check on the offered command; order before full
	always_comb begin
		if (req.command == CMD_EXACT) begin
			req_lst = req.extended ? LST_EE : LST_SE;
		end else begin
			req_lst = req.extended ? LST_ER : LST_SR;
		end
		req_status = ST_OK;
		if (req.command == CMD_RANGE && req.id_low > req.id_high) begin
			req_status = ST_ORDER;
		end else if ((req.command == CMD_EXACT || req.command == CMD_RANGE) &&
			cnt_q[req_lst] >= list_slots(req_lst)) begin
			req_status = ST_FULL;
		end
	end

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = list_base(lst_q) + ADDR_W'(p_q);
		ram_wdata = entry_q;
		ram_raddr = list_base(lst_q) + ADDR_W'(p_q) - ADDR_W'(1);
		unique case (state_q)
			S_INS_RD: begin
				ram_we = (p_q == '0);
			end
			S_INS_CHK: begin
				ram_we    = 1'b1;
				ram_wdata = key_gt ? ram_rdata : entry_q;
			end
			S_EMIT_RD: begin
				ram_raddr = list_base(sec_q) + ADDR_W'(i_q);
			end
			S_EMIT_DAT: begin
				ram_raddr = list_base(sec_q) + ADDR_W'(i_q) + ADDR_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_xfer) begin
					case (req.command) inside
						CMD_EXACT, CMD_RANGE: state_d = (req_status == ST_OK) ? S_INS_RD : S_RESP;
						CMD_CLEAR:            state_d = S_RESP;
						default:              state_d = S_IDLE;
					endcase
				end
			end
			S_INS_RD:  state_d = (p_q == '0) ? S_EMIT_RD : S_INS_CHK;
			S_INS_CHK: state_d = key_gt ? S_INS_RD : S_EMIT_RD;
			S_EMIT_RD: begin
				if (i_q < cnt_q[sec_q]) begin
					state_d = S_EMIT_DAT;
				end else if (sec_q == LST_ER) begin
					state_d = S_IDLE;
				end
			end
			S_EMIT_DAT: begin
				if (!(sec_q == LST_SE && !half_q && (i_q + CNT_W'(1)) < cnt_q[LST_SE])) begin
					state_d = S_EMIT_OUT;
				end
			end
			S_EMIT_OUT: begin
				if (out_free) begin
					if (last_word) begin
						state_d = S_IDLE;
					end else if (sec_q == LST_ER && half_q) begin
						state_d = S_EMIT_DAT;
					end else begin
						state_d = S_EMIT_RD;
					end
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			filt_q   <= 1'b0;
			ov_q     <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				cnt_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (req_xfer && req.command == CMD_CLEAR) begin
				filt_q <= 1'b0;
				for (int k = 0; k < 4; k++) begin
					cnt_q[k] <= '0;
				end
			end
			// entry placed: list grows, table goes live
			if ((state_q == S_INS_RD && p_q == '0) || (state_q == S_INS_CHK && !key_gt)) begin
				cnt_q[lst_q] <= cnt_q[lst_q] + CNT_W'(1);
				filt_q       <= 1'b1;
			end
			if ((state_q == S_EMIT_OUT || state_q == S_RESP) && out_free) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// command and sequencer datapath
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			// rejects are decided at accept time
			status_q <= req_status;
			lst_q    <= req_lst;
			if (req.command == CMD_EXACT) begin
				if (req.extended) begin
					entry_q <= ENTRY_W'({req.channel, req.id_low});
				end else begin
					entry_q <= ENTRY_W'({req.channel, req.id_low[10:0]});
				end
			end else begin
				if (req.extended) begin
					entry_q <= {req.channel, req.id_low, req.id_high};
				end else begin
					entry_q <= ENTRY_W'({req.channel, req.id_low[10:0], req.id_high[10:0]});
				end
			end
			p_q <= cnt_q[req_lst];
		end
		if (state_q == S_INS_CHK) begin
			p_q <= p_q - CNT_W'(1);
		end
		if ((state_q == S_INS_RD && p_q == '0) || (state_q == S_INS_CHK && !key_gt)) begin
			sec_q    <= LST_SE;
			i_q      <= '0;
			half_q   <= 1'b0;
			emit_n_q <= '0;
		end
		if (state_q == S_EMIT_RD && !(i_q < cnt_q[sec_q])) begin
			sec_q <= lst_t'(sec_q + 2'd1);
			i_q   <= '0;
		end
		if (state_q == S_EMIT_DAT) begin
			word_q <= pword;
			case (sec_q)
				LST_SE: begin
					if (!half_q && (i_q + CNT_W'(1)) < cnt_q[LST_SE]) begin
						hi16_q <= entry16(ram_rdata[11], ram_rdata[10:0]);
						half_q <= 1'b1;
					end else begin
						half_q <= 1'b0;
					end
					i_q <= i_q + CNT_W'(1);
				end
				LST_ER: begin
					if (!half_q) begin
						hold_q <= ram_rdata;
						half_q <= 1'b1;
					end else begin
						half_q <= 1'b0;
						i_q    <= i_q + CNT_W'(1);
					end
				end
				default: i_q <= i_q + CNT_W'(1);
			endcase
		end
		if (state_q == S_EMIT_OUT && out_free) begin
			emit_n_q <= emit_n_q + RES_W'(1);
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT_OUT && out_free) begin
			o_status_q <= ST_OK;
			o_has_q    <= 1'b1;
			o_addr_q   <= emit_n_q[4:0];
			o_word_q   <= word_q;
			o_last_q   <= last_word;
			o_acc_q    <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				o_off_q[k] <= offs[k];
			end
		end else if (state_q == S_RESP && out_free) begin
			o_status_q <= status_q;
			o_has_q    <= 1'b0;
			o_addr_q   <= '0;
			o_word_q   <= '0;
			o_last_q   <= 1'b1;
			o_acc_q    <= !filt_q;
			for (int k = 0; k < 4; k++) begin
				o_off_q[k] <= '0;
			end
		end
	end

	assign rsp.valid           = ov_q;
	assign rsp.status          = o_status_q;
	assign rsp.has_word        = o_has_q;
	assign rsp.word_address    = o_addr_q;
	assign rsp.table_word      = o_word_q;
	assign rsp.last            = o_last_q;
	assign rsp.std_range_start = o_off_q[0];
	assign rsp.ext_exact_start = o_off_q[1];
	assign rsp.ext_range_start = o_off_q[2];
	assign rsp.table_end       = o_off_q[3];
	assign rsp.accept_all      = o_acc_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[LST_SE] <= list_slots(LST_SE) && cnt_q[LST_SR] <= list_slots(LST_SR) &&
		cnt_q[LST_EE] <= list_slots(LST_EE) && cnt_q[LST_ER] <= list_slots(LST_ER))
		else $error("filter list count above capacity");

	a_we_ins: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_INS_RD || state_q == S_INS_CHK))
		else $error("list RAM write outside insert");

	a_word_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.has_word |-> rsp.status == ST_OK && !rsp.accept_all)
		else $error("table word with bad status");

	a_reject_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP) |-> !ram_we)
		else $error("write during single-result response");

endmodule

// ===== rtl/cafb_ram.sv =====
module cafb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/cafb_pack.sv =====
module cafb_pack (
	input  cafb_pkg::pack_ctl_t          ctl,
	input  logic [cafb_pkg::ENTRY_W-1:0] data,
	output logic [31:0]                  word
);
	import cafb_pkg::*;

	always_comb begin
		case (ctl.sec)
			LST_SE: begin
				word = ctl.half ? {ctl.hi16, entry16(data[11], data[10:0])}
					: {entry16(data[11], data[10:0]), FILL16};
			end
			LST_SR: begin
				word = {entry16(data[22], data[21:11]), entry16(data[22], data[10:0])};
			end
			LST_EE: begin
				word = {2'b00, data[29:0]};
			end
			default: begin
				// low bound word first, then high bound word
				word = ctl.half ? {2'b00, data[58], data[28:0]}
					: {2'b00, data[58], data[57:29]};
			end
		endcase
	end
endmodule
